### rtl/kst_pkg.sv
// shared types and constants for the keyed record slot table
package kst_pkg;

    localparam int DATA_W = 64;
    localparam int SLOT_W = 6;
    localparam int ACT_W = 2;
    localparam int STAT_W = 2;
    localparam logic [7:0] FREE_BYTE = 8'hFF;

    typedef enum logic [ACT_W-1:0] {
        ACT_SAVE   = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_LOAD   = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        SEL_CNT,
        SEL_IDX,
        SEL_SLOT
    } addr_sel_t;

    typedef struct packed {
        logic      item_load;
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      wr_en;
        addr_sel_t wr_sel;
        logic      wr_ones;
        logic      out_load;
        status_t   status;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    hit;
        logic    slot_ok;
    } stat_t;

endpackage

### rtl/kst_ctrl.sv
// controller state machine: clearing pass, slot scan and result handoff
module kst_ctrl #(
    parameter int NUM_SLOTS = 64,
    parameter int AW = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  kst_pkg::stat_t       sts,
    output kst_pkg::cmd_t        cmd,
    output logic [AW-1:0]        scan_addr
);

    kst_pkg::state_t  state_reg, state_next;
    logic [AW:0]      cnt_reg, cnt_next;
    kst_pkg::status_t stat_reg, stat_next;
    logic             out_valid_reg, out_valid_next;

    localparam logic [AW:0] CNT_LAST = (AW+1)'(NUM_SLOTS - 1);
    localparam logic [AW:0] CNT_END  = (AW+1)'(NUM_SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kst_pkg::S_CLEAR;
            cnt_reg       <= '0;
            stat_reg      <= kst_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        stat_next    = stat_reg;
        cmd.item_load = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_sel   = kst_pkg::SEL_CNT;
        cmd.wr_en    = 1'b0;
        cmd.wr_sel   = kst_pkg::SEL_CNT;
        cmd.wr_ones  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.status   = stat_reg;

        case (state_reg)
            kst_pkg::S_CLEAR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_ones = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = kst_pkg::S_IDLE;
                end
            end
            kst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    cnt_next      = (AW+1)'(1);
                    state_next    = kst_pkg::S_EXEC;
                end
            end
            kst_pkg::S_EXEC:
            begin
                stat_next = kst_pkg::ST_OK;
                case (sts.action)
                    kst_pkg::ACT_SAVE, kst_pkg::ACT_SEARCH:
                    begin
                        cmd.rd_en  = 1'b1;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = kst_pkg::S_SCAN;
                    end
                    kst_pkg::ACT_DELETE:
                    begin
                        cmd.wr_en   = sts.slot_ok;
                        cmd.wr_sel  = kst_pkg::SEL_SLOT;
                        cmd.wr_ones = 1'b1;
                        state_next  = kst_pkg::S_RESP;
                    end
                    default:
                    begin
                        cmd.rd_en  = sts.slot_ok;
                        cmd.rd_sel = kst_pkg::SEL_SLOT;
                        state_next = kst_pkg::S_RESP;
                    end
                endcase
            end
            kst_pkg::S_SCAN:
            begin
                // the read issued last cycle is checked here, next one goes out
                if (sts.hit)
                begin
                    cmd.wr_en  = (sts.action == kst_pkg::ACT_SAVE);
                    cmd.wr_sel = kst_pkg::SEL_IDX;
                    stat_next  = kst_pkg::ST_OK;
                    state_next = kst_pkg::S_RESP;
                end
                else if (cnt_reg == CNT_END)
                begin
                    stat_next  = (sts.action == kst_pkg::ACT_SAVE) ?
                                 kst_pkg::ST_FULL : kst_pkg::ST_MISS;
                    state_next = kst_pkg::S_RESP;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            kst_pkg::S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = kst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kst_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    assign in_stall  = (state_reg != kst_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign scan_addr = cnt_reg[AW-1:0];

endmodule

### rtl/kst_datapath.sv
// datapath: item registers, record memory, match logic and output register
module kst_datapath #(
    parameter int NUM_SLOTS = 64,
    parameter int KEY_BYTES = 8,
    parameter int AW = 6
) (
    input  logic                                clk,
    input  logic [kst_pkg::ACT_W-1:0]           action,
    input  logic [kst_pkg::SLOT_W-1:0]          slot,
    input  logic [kst_pkg::DATA_W-1:0]          key,
    input  logic [kst_pkg::DATA_W-1:0]          flag_bytes,
    output logic [kst_pkg::SLOT_W-1:0]          result_slot,
    output logic [kst_pkg::STAT_W-1:0]          status,
    output logic [kst_pkg::DATA_W-1:0]          key_out,
    output logic [kst_pkg::DATA_W-1:0]          flags_out,
    input  kst_pkg::cmd_t                       cmd,
    input  logic [AW-1:0]                       scan_addr,
    output kst_pkg::stat_t                      sts
);

    localparam logic [kst_pkg::DATA_W-1:0] KEY_MASK =
        {kst_pkg::DATA_W{1'b1}} >> (8 * (8 - KEY_BYTES));

    logic [kst_pkg::DATA_W-1:0] key_mem  [NUM_SLOTS];
    logic [kst_pkg::DATA_W-1:0] flag_mem [NUM_SLOTS];

    kst_pkg::action_t            action_reg;
    logic [kst_pkg::SLOT_W-1:0]  slot_reg;
    logic [kst_pkg::DATA_W-1:0]  key_reg;
    logic [kst_pkg::DATA_W-1:0]  flags_reg;
    logic [kst_pkg::DATA_W-1:0]  rd_key_reg;
    logic [kst_pkg::DATA_W-1:0]  rd_flags_reg;
    logic [AW-1:0]               rd_idx_reg;
    logic [kst_pkg::SLOT_W-1:0]  res_slot_reg;
    logic [kst_pkg::STAT_W-1:0]  res_status_reg;
    logic [kst_pkg::DATA_W-1:0]  res_key_reg;
    logic [kst_pkg::DATA_W-1:0]  res_flags_reg;

    logic [AW+kst_pkg::SLOT_W-1:0] slot_wide;
    logic [AW+kst_pkg::SLOT_W-1:0] idx_wide;
    logic [AW-1:0]                 slot_addr;
    logic [kst_pkg::SLOT_W-1:0]    idx_slot;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic [kst_pkg::DATA_W-1:0]    wr_key;
    logic [kst_pkg::DATA_W-1:0]    wr_flags;
    logic                          slot_ok;
    logic                          hit;
    logic                          is_scan;
    logic                          is_load;

    assign slot_wide = {{AW{1'b0}}, slot_reg};
    assign idx_wide  = {{kst_pkg::SLOT_W{1'b0}}, rd_idx_reg};
    assign slot_addr = slot_wide[AW-1:0];
    assign idx_slot  = idx_wide[kst_pkg::SLOT_W-1:0];
    assign slot_ok   = ({26'b0, slot_reg} < 32'(NUM_SLOTS));

    always_comb
    begin
        case (cmd.rd_sel)
            kst_pkg::SEL_SLOT: rd_addr = slot_addr;
            kst_pkg::SEL_IDX:  rd_addr = rd_idx_reg;
            default:           rd_addr = scan_addr;
        endcase
        case (cmd.wr_sel)
            kst_pkg::SEL_SLOT: wr_addr = slot_addr;
            kst_pkg::SEL_IDX:  wr_addr = rd_idx_reg;
            default:           wr_addr = scan_addr;
        endcase
    end

    assign wr_key   = cmd.wr_ones ? {kst_pkg::DATA_W{1'b1}} : (key_reg & KEY_MASK);
    assign wr_flags = cmd.wr_ones ? {kst_pkg::DATA_W{1'b1}} : flags_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            action_reg <= kst_pkg::action_t'(action);
            slot_reg   <= slot;
            key_reg    <= key;
            flags_reg  <= flag_bytes;
        end
        if (cmd.wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            flag_mem[wr_addr] <= wr_flags;
        end
        if (cmd.rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_flags_reg <= flag_mem[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    // save looks for a free slot, search for a key match
    always_comb
    begin
        case (action_reg)
            kst_pkg::ACT_SAVE:
                hit = (rd_flags_reg[kst_pkg::DATA_W-1 -: 8] == kst_pkg::FREE_BYTE);
            kst_pkg::ACT_SEARCH:
                hit = ((rd_key_reg & KEY_MASK) == (key_reg & KEY_MASK));
            default:
                hit = 1'b0;
        endcase
    end

    assign sts.action  = action_reg;
    assign sts.hit     = hit;
    assign sts.slot_ok = slot_ok;

    assign is_scan = (action_reg == kst_pkg::ACT_SAVE) || (action_reg == kst_pkg::ACT_SEARCH);
    assign is_load = (action_reg == kst_pkg::ACT_LOAD);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (is_scan)
                res_slot_reg <= (cmd.status == kst_pkg::ST_OK) ? idx_slot : '0;
            else
                res_slot_reg <= slot_reg;
            res_status_reg <= cmd.status;
            res_key_reg    <= (is_load && slot_ok) ? rd_key_reg : '0;
            res_flags_reg  <= (is_load && slot_ok) ? rd_flags_reg : '0;
        end
    end

    assign result_slot = res_slot_reg;
    assign status      = res_status_reg;
    assign key_out     = res_key_reg;
    assign flags_out   = res_flags_reg;

endmodule

### rtl/keyed_record_slot_table_top.sv
// top level of the keyed record slot table
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  action, slot, key, flag_bytes
//  out      output     out_valid/out_stall result_slot, status, key_out, flags_out
//
// after reset every slot of the table is cleared to all ones while in_stall is high
// save and search scan one slot per cycle through the single memory read port and
// stop at the first hit or after the last slot; delete and load go straight to the result state
// the block takes one transaction at a time and accepts the next one once
// its result has entered the output register; a stalled result holds the output register
module keyed_record_slot_table_top #(
    parameter int NUM_SLOTS = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [kst_pkg::ACT_W-1:0]  action,
    input  logic [kst_pkg::SLOT_W-1:0] slot,
    input  logic [kst_pkg::DATA_W-1:0] key,
    input  logic [kst_pkg::DATA_W-1:0] flag_bytes,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [kst_pkg::SLOT_W-1:0] result_slot,
    output logic [kst_pkg::STAT_W-1:0] status,
    output logic [kst_pkg::DATA_W-1:0] key_out,
    output logic [kst_pkg::DATA_W-1:0] flags_out
);

    localparam int AW = $clog2(NUM_SLOTS);

    kst_pkg::cmd_t  cmd;
    kst_pkg::stat_t sts;
    logic [AW-1:0]  scan_addr;

    kst_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    kst_datapath #(
        .NUM_SLOTS (NUM_SLOTS),
        .KEY_BYTES (KEY_BYTES),
        .AW        (AW)
    ) u_datapath (
        .clk         (clk),
        .action      (action),
        .slot        (slot),
        .key         (key),
        .flag_bytes  (flag_bytes),
        .result_slot (result_slot),
        .status      (status),
        .key_out     (key_out),
        .flags_out   (flags_out),
        .cmd         (cmd),
        .scan_addr   (scan_addr),
        .sts         (sts)
    );

endmodule
